>>> sv/strided_histogram_with_find_defines.svh
`ifndef STRIDED_HISTOGRAM_WITH_FIND_DEFINES_SVH
`define STRIDED_HISTOGRAM_WITH_FIND_DEFINES_SVH

// same-cycle implication, checked on every clock once reset is released
`define SHWF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shwf: same-cycle check failed");

// next-cycle implication
`define SHWF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shwf: next-cycle check failed");

`endif

>>> sv/shwf_pkg.sv
`timescale 1ns / 1ps

package shwf_pkg;

    localparam int TABLE_DEPTH = 1048576;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int FIELD_W     = 21;
    localparam int COUNT_W     = 8;
    localparam int IDX_W       = FIELD_W + 1;
    localparam int PROD_W      = 2 * FIELD_W + 1;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [FIELD_W-1:0] range_start;
        logic [FIELD_W-1:0] range_end;
        logic [FIELD_W-1:0] multiplier;
        logic [COUNT_W-1:0] target_count;
    } t_item;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] position_doubled;
        logic               dropped;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [COUNT_W-1:0] wdata;
        logic [ADDR_W-1:0]  raddr;
    } t_mem_req;

    // twice the entry position, kept to the field width
    function automatic logic [FIELD_W-1:0] double_pos(input logic [ADDR_W-1:0] pos);
        logic [ADDR_W+FIELD_W:0] w;
        w = {{(FIELD_W + 1){1'b0}}, pos} << 1;
        return w[FIELD_W-1:0];
    endfunction

endpackage

>>> sv/shwf_if.sv
`timescale 1ns / 1ps

interface shwf_item_if;
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic [shwf_pkg::FIELD_W-1:0]   range_start;
    logic [shwf_pkg::FIELD_W-1:0]   range_end;
    logic [shwf_pkg::FIELD_W-1:0]   multiplier;
    logic [shwf_pkg::COUNT_W-1:0]   target_count;

    modport source (output valid, opcode, range_start, range_end, multiplier, target_count,
                    input ready);
    modport sink (input valid, opcode, range_start, range_end, multiplier, target_count,
                  output ready);
endinterface

interface shwf_result_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [shwf_pkg::FIELD_W-1:0]   position_doubled;
    logic                           dropped;

    modport source (output valid, found, position_doubled, dropped, input ready);
    modport sink (input valid, found, position_doubled, dropped, output ready);
endinterface

>>> sv/shwf_ram.sv
`timescale 1ns / 1ps

module shwf_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents when the same entry is written in that cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/shwf_seq.sv
`timescale 1ns / 1ps

module shwf_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    output logic                          o_item_ready,
    input  shwf_pkg::t_item               i_item,
    output logic                          o_done,
    input  logic                          i_take,
    output shwf_pkg::t_result             o_result,
    output shwf_pkg::t_mem_req            o_mem,
    input  logic [shwf_pkg::COUNT_W-1:0]  i_rdata
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam int AW = shwf_pkg::ADDR_W;
    localparam int CW = shwf_pkg::CNT_W;
    localparam int PW = shwf_pkg::PROD_W;
    localparam int IW = shwf_pkg::IDX_W;
    localparam int FW = shwf_pkg::FIELD_W;
    localparam int DW = shwf_pkg::COUNT_W;

    logic [2:0]        r_state,  n_state;
    shwf_pkg::t_item   r_item,   n_item;
    logic [PW-1:0]     r_prod,   n_prod;
    logic [IW-1:0]     r_idx,    n_idx;
    logic [CW-1:0]     r_cnt,    n_cnt;
    logic              r_drop,   n_drop;
    logic              r_found,  n_found;
    logic [AW-1:0]     r_pos,    n_pos;
    logic              r_p_valid, n_p_valid;
    logic [AW-1:0]     r_p_addr, n_p_addr;
    logic              r_w_valid, n_w_valid;
    logic [AW-1:0]     r_w_addr, n_w_addr;
    logic [DW-1:0]     r_w_data, n_w_data;

    logic [2*FW-1:0]   start_prod;
    logic [PW-2:0]     addr_half;
    logic              in_table;
    logic [DW-1:0]     rmw_value;
    logic              match;

    assign start_prod = i_item.range_start * i_item.multiplier;
    assign addr_half  = r_prod[PW-1:1];
    assign in_table   = addr_half < (PW - 1)'(shwf_pkg::TABLE_DEPTH);
    // the write of the previous cycle is not yet in the read data
    assign rmw_value  = (r_w_valid && (r_w_addr == r_p_addr)) ? r_w_data : i_rdata;
    assign match      = r_p_valid && (i_rdata == r_item.target_count);

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_prod    = r_prod;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_drop    = r_drop;
        n_found   = r_found;
        n_pos     = r_pos;
        n_p_valid = 1'b0;
        n_p_addr  = r_p_addr;
        n_w_valid = 1'b0;
        n_w_addr  = r_w_addr;
        n_w_data  = r_w_data;
        o_item_ready = 1'b0;
        o_done       = 1'b0;
        o_mem.we     = 1'b0;
        o_mem.waddr  = r_p_addr;
        o_mem.wdata  = rmw_value + DW'(1);
        o_mem.raddr  = '0;

        // increment stage: the entry read last cycle is written back
        if (r_p_valid && (r_item.opcode == shwf_pkg::OP_ADD)) begin
            o_mem.we  = 1'b1;
            n_w_valid = 1'b1;
            n_w_addr  = r_p_addr;
            n_w_data  = o_mem.wdata;
        end

        case (r_state)
            S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_cnt[AW-1:0];
                o_mem.wdata = '0;
                n_cnt       = r_cnt + CW'(1);
                if (r_cnt == CW'(shwf_pkg::TABLE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    n_item  = i_item;
                    n_prod  = {{(PW - 2 * FW){1'b0}}, start_prod};
                    n_idx   = {1'b0, i_item.range_start};
                    n_cnt   = '0;
                    n_drop  = 1'b0;
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_state = (i_item.opcode == shwf_pkg::OP_ADD) ? S_WALK : S_SCAN;
                end
            end
            S_WALK: begin
                if (r_idx > {1'b0, r_item.range_end}) begin
                    n_state = S_DONE;
                end else begin
                    if (in_table) begin
                        o_mem.raddr = addr_half[AW-1:0];
                        n_p_valid   = 1'b1;
                        n_p_addr    = addr_half[AW-1:0];
                    end else begin
                        n_drop = 1'b1;
                    end
                    n_idx  = r_idx + IW'(2);
                    n_prod = r_prod + {{(PW - FW - 1){1'b0}}, r_item.multiplier, 1'b0};
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_found = 1'b1;
                    n_pos   = r_p_addr;
                    n_state = S_DONE;
                end else if (r_cnt == CW'(shwf_pkg::TABLE_DEPTH)) begin
                    if (!r_p_valid) begin
                        n_state = S_DONE;
                    end
                end else begin
                    o_mem.raddr = r_cnt[AW-1:0];
                    n_p_valid   = 1'b1;
                    n_p_addr    = r_cnt[AW-1:0];
                    n_cnt       = r_cnt + CW'(1);
                end
            end
            S_DONE: begin
                o_done = 1'b1;
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_p_valid <= 1'b0;
            r_w_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_p_valid <= n_p_valid;
            r_w_valid <= n_w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_prod   <= n_prod;
        r_idx    <= n_idx;
        r_drop   <= n_drop;
        r_found  <= n_found;
        r_pos    <= n_pos;
        r_p_addr <= n_p_addr;
        r_w_addr <= n_w_addr;
        r_w_data <= n_w_data;
    end

    assign o_result.found            = r_found;
    assign o_result.position_doubled = shwf_pkg::double_pos(r_pos);
    assign o_result.dropped          = r_drop;

endmodule

>>> sv/strided_histogram_with_find.sv
// add: from start to end, every second index in the table is read and written back
// find: reads entries upward from 0 up to the first hit, or the whole table on a miss
// one item at a time; the counter memory has one read port and one write port
// the next item can be taken in the cycle after the result enters the output register
// reset: synchronous active-low; a clearing pass zeroes all TABLE_DEPTH (1048576)
// entries of the table, and no item is accepted until it ends
`timescale 1ns / 1ps
`include "strided_histogram_with_find_defines.svh"

module strided_histogram_with_find (
    input  logic               i_clk,
    input  logic               i_rst_n,
    shwf_item_if.sink          i_item,
    shwf_result_if.source      o_result
);

    shwf_pkg::t_item     item;
    shwf_pkg::t_result   seq_result;
    shwf_pkg::t_mem_req  mem_req;
    logic [shwf_pkg::COUNT_W-1:0] mem_rdata;
    logic                seq_done;
    logic                take;

    logic                r_o_valid;
    shwf_pkg::t_result   r_o_result;

    assign item.opcode       = i_item.opcode;
    assign item.range_start  = i_item.range_start;
    assign item.range_end    = i_item.range_end;
    assign item.multiplier   = i_item.multiplier;
    assign item.target_count = i_item.target_count;

    shwf_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (i_item.ready),
        .i_item       (item),
        .o_done       (seq_done),
        .i_take       (take),
        .o_result     (seq_result),
        .o_mem        (mem_req),
        .i_rdata      (mem_rdata)
    );

    shwf_ram #(
        .DEPTH (shwf_pkg::TABLE_DEPTH),
        .WIDTH (shwf_pkg::COUNT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // output register frees the sequencer while the result waits
    assign take = seq_done && (!r_o_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (take) begin
            r_o_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_o_result <= seq_result;
        end
    end

    assign o_result.valid            = r_o_valid;
    assign o_result.found            = r_o_result.found;
    assign o_result.position_doubled = r_o_result.position_doubled;
    assign o_result.dropped          = r_o_result.dropped;

    `SHWF_ASSERT_NEXT(a_busy_after_accept, i_item.valid && i_item.ready, !i_item.ready)
    `SHWF_ASSERT_NOW(a_no_overwrite, take, !r_o_valid || o_result.ready)
    `SHWF_ASSERT_NOW(a_find_not_dropped, r_o_valid && r_o_result.found, !r_o_result.dropped)
    `SHWF_ASSERT_NOW(a_miss_pos_zero, r_o_valid && !r_o_result.found,
                     r_o_result.position_doubled == '0)

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int FIELD_W     = shwf_pkg::FIELD_W;
    localparam int COUNT_W     = shwf_pkg::COUNT_W;
    localparam int TABLE_DEPTH = shwf_pkg::TABLE_DEPTH;

    localparam int FIELD_MAX   = (1 << FIELD_W) - 1;
    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int RANDOM_ITEMS = 560;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        shwf_pkg::t_item   item;
        bit                typed;
        shwf_pkg::t_result want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    shwf_item_if   item_bus();
    shwf_result_if result_bus();

    strided_histogram_with_find DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    // sparse copy of the counter table: absent entries are zero
    bit [COUNT_W-1:0]  tally [int];
    shwf_pkg::t_result pending_results[$];

    int  err_count    = 0;
    int  cycle_cnt    = 0;
    int  results_seen = 0;
    int  drops_seen   = 0;
    int  hits_seen    = 0;
    int  n_adds       = 0;
    int  n_finds      = 0;
    int  burst_left   = 0;
    bit  held_off     = 1'b0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still pending", cycle_cnt,
                 pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch %0d: %s", $time, err_count, msg);
    endtask

    // first entry holding the given count, scanning upward from entry 0
    function automatic void locate_count(input logic [COUNT_W-1:0] want, output bit hit,
                                         output int pos);
        int k;
        hit = 1'b0;
        pos = 0;
        if (want == 0) begin
            k = 0;
            while (k < TABLE_DEPTH && tally.exists(k) && tally[k] != 0) k++;
            if (k < TABLE_DEPTH) begin
                hit = 1'b1;
                pos = k;
            end
        end else if (tally.first(k)) begin
            do begin
                if (tally[k] == want) begin
                    hit = 1'b1;
                    pos = k;
                    break;
                end
            end while (tally.next(k));
        end
    endfunction

    function automatic shwf_pkg::t_result histogram_step(input shwf_pkg::t_item it);
        shwf_pkg::t_result r;
        longint unsigned   i;
        longint unsigned   addr;
        int                pos;
        bit                hit;
        r = '0;
        if (it.opcode == shwf_pkg::OP_ADD) begin
            for (i = it.range_start; i <= it.range_end; i += 2) begin
                addr = (it.multiplier * i) >> 1;
                if (addr < TABLE_DEPTH)
                    tally[int'(addr)] = tally.exists(int'(addr)) ?
                                        tally[int'(addr)] + 8'd1 : 8'd1;
                else
                    r.dropped = 1'b1;
            end
        end else begin
            locate_count(it.target_count, hit, pos);
            if (hit) begin
                r.found            = 1'b1;
                r.position_doubled = FIELD_W'(pos << 1);
            end
        end
        return r;
    endfunction

    function automatic t_row mk_row(input logic op, input int unsigned s, input int unsigned e,
                                    input int unsigned m, input int unsigned t,
                                    input bit typed, input logic f, input int unsigned p,
                                    input logic d);
        t_row row;
        row.item.opcode            = op;
        row.item.range_start       = FIELD_W'(s);
        row.item.range_end         = FIELD_W'(e);
        row.item.multiplier        = FIELD_W'(m);
        row.item.target_count      = COUNT_W'(t);
        row.typed                  = typed;
        row.want.found             = f;
        row.want.position_doubled  = FIELD_W'(p);
        row.want.dropped           = d;
        return row;
    endfunction

    // one transfer on the item channel, with burst and gap shaping
    task automatic send(input shwf_pkg::t_item it, input bit typed,
                        input shwf_pkg::t_result want);
        int gap;
        shwf_pkg::t_result predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 4) ? 0 :
                  ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                item_bus.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        item_bus.opcode       <= it.opcode;
        item_bus.range_start  <= it.range_start;
        item_bus.range_end    <= it.range_end;
        item_bus.multiplier   <= it.multiplier;
        item_bus.target_count <= it.target_count;
        item_bus.valid        <= 1'b1;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        predicted = histogram_step(it);
        pending_results.push_back(typed ? want : predicted);
        if (it.opcode == shwf_pkg::OP_ADD) n_adds++;
        else n_finds++;
        burst_left--;
    endtask

    // result checker
    always @(posedge i_clk) begin
        shwf_pkg::t_result want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            results_seen++;
            if (result_bus.dropped === 1'b1) drops_seen++;
            if (result_bus.found === 1'b1) hits_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch("result transfer with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (result_bus.found !== want.found)
                    flag_mismatch($sformatf("found got %b want %b",
                                            result_bus.found, want.found));
                if (result_bus.position_doubled !== want.position_doubled)
                    flag_mismatch($sformatf("position_doubled got %0d want %0d",
                                            result_bus.position_doubled,
                                            want.position_doubled));
                if (result_bus.dropped !== want.dropped)
                    flag_mismatch($sformatf("dropped got %b want %b",
                                            result_bus.dropped, want.dropped));
            end
        end
    end

    // result side: stall patterns taken bit by bit from a 32-bit random word, plus one long hold-off
    initial begin : result_sink
        int          k;
        int          mode;
        logic [31:0] pat;
        result_bus.ready = 1'b0;
        forever begin
            if (!held_off && results_seen >= 120) begin
                held_off = 1'b1;
                for (k = 0; k < HOLD_CYCLES; k++) begin
                    @(negedge i_clk);
                    result_bus.ready <= 1'b0;
                end
            end
            mode = $urandom_range(0, 3);
            pat  = $urandom;
            if (mode == 3) pat = pat & $urandom;
            for (k = 0; k < 32; k++) begin
                @(negedge i_clk);
                result_bus.ready <= (mode == 0) ? 1'b1 : pat[k];
            end
        end
    end

    initial begin : stimulus
        t_row              plan[$];
        shwf_pkg::t_item   it;
        int      n;
        int      r;
        int      s;
        int      e;
        int      p;
        int      pos;
        bit      hit;

        i_rst_n               = 1'b0;
        item_bus.valid        = 1'b0;
        item_bus.opcode       = shwf_pkg::OP_ADD;
        item_bus.range_start  = '0;
        item_bus.range_end    = '0;
        item_bus.multiplier   = '0;
        item_bus.target_count = '0;

        // table is all zero after reset
        plan.push_back(mk_row(shwf_pkg::OP_FIND, 0, 0, 0, 0, 1, 1'b1, 0, 1'b0));
        // miss scans the whole table
        plan.push_back(mk_row(shwf_pkg::OP_FIND, 0, 0, 0, 1, 1, 1'b0, 0, 1'b0));
        // empty ranges
        plan.push_back(mk_row(shwf_pkg::OP_ADD, 5, 4, 3, 0, 1, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(shwf_pkg::OP_ADD, FIELD_MAX, 0, FIELD_MAX, 255, 1,
                              1'b0, 0, 1'b0));
        // single index far past the table
        plan.push_back(mk_row(shwf_pkg::OP_ADD, FIELD_MAX, FIELD_MAX, FIELD_MAX, 0, 1,
                              1'b0, 0, 1'b1));
        // lands on the last entry
        plan.push_back(mk_row(shwf_pkg::OP_ADD, FIELD_MAX, FIELD_MAX, 1, 0, 1, 1'b0, 0, 1'b0));
        // zero multiplier piles 255 counts on entry 0
        plan.push_back(mk_row(shwf_pkg::OP_ADD, 0, 508, 0, 0, 1, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(shwf_pkg::OP_FIND, 0, 0, 0, 255, 1, 1'b1, 0, 1'b0));
        // entry 0 wraps back to zero
        plan.push_back(mk_row(shwf_pkg::OP_ADD, 0, 0, 0, 0, 1, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(shwf_pkg::OP_FIND, 0, 0, 0, 0, 1, 1'b1, 0, 1'b0));
        plan.push_back(mk_row(shwf_pkg::OP_ADD, 1, 9, 1, 0, 0, 1'b0, 0, 1'b0));
        // straddles the top of the table
        plan.push_back(mk_row(shwf_pkg::OP_ADD, 1048570, 1048590, 2, 0, 0, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(shwf_pkg::OP_FIND, FIELD_MAX, FIELD_MAX, FIELD_MAX, 1, 0,
                              1'b0, 0, 1'b0));
        plan.push_back(mk_row(shwf_pkg::OP_ADD, 0, 20, 2, 0, 0, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(shwf_pkg::OP_FIND, 0, 0, 0, 2, 0, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(shwf_pkg::OP_ADD, 0, 4094, 1, 0, 0, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(shwf_pkg::OP_FIND, 0, 0, 0, 0, 0, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(shwf_pkg::OP_FIND, 0, 0, 0, 3, 0, 1'b0, 0, 1'b0));
        plan.push_back(mk_row(shwf_pkg::OP_ADD, 2, 2, FIELD_MAX, 0, 0, 1'b0, 0, 1'b0));

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) send(plan[k].item, plan[k].typed, plan[k].want);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            it.range_start  = FIELD_W'($urandom);
            it.range_end    = FIELD_W'($urandom);
            it.multiplier   = FIELD_W'($urandom);
            it.target_count = COUNT_W'($urandom);
            if (r < 60) begin
                // dense adds in the low part of the table
                it.opcode = shwf_pkg::OP_ADD;
                s = $urandom_range(0, 2047);
                e = s + $urandom_range(0, 40);
                if ($urandom_range(0, 9) == 0) e = s - $urandom_range(1, 5);
                it.range_start = FIELD_W'(s);
                it.range_end   = FIELD_W'((e < 0) ? 0 : e);
                it.multiplier  = FIELD_W'($urandom_range(0, 4));
            end else if (r < 75) begin
                // wide fields: empty ranges or a few mostly dropped addresses
                it.opcode = shwf_pkg::OP_ADD;
                s = $urandom & FIELD_MAX;
                e = $urandom & FIELD_MAX;
                if (e > s) e = s + $urandom_range(0, 6);
                if (e > FIELD_MAX) e = FIELD_MAX;
                it.range_start = FIELD_W'(s);
                it.range_end   = FIELD_W'(e);
            end else begin
                // finds, kept to targets whose first match is near the bottom
                it.opcode = shwf_pkg::OP_FIND;
                hit = 1'b0;
                pos = 0;
                if ($urandom_range(0, 3) == 0) locate_count(it.target_count, hit, pos);
                if (!hit || pos > 8191) begin
                    p = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) :
                                                      $urandom_range(0, 511);
                    it.target_count = tally.exists(p) ? tally[p] : '0;
                end
            end
            send(it, 1'b0, '0);
        end

        @(negedge i_clk);
        item_bus.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("covered %0d adds (%0d flagged dropped) and %0d finds (%0d hits)",
                 n_adds, drops_seen, n_finds, hits_seen);
        $display("%0d results checked in %0d cycles, %0d mismatches",
                 results_seen, cycle_cnt, err_count);
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
